[src/log_ring_fifo_with_packet_drain_top_assert.svh]
// assertion macros for the message ring fifo top level
// no dependencies; the macros expand to nothing when SYNTH is defined
`ifndef LOG_RING_FIFO_WITH_PACKET_DRAIN_TOP_ASSERT_SVH
`define LOG_RING_FIFO_WITH_PACKET_DRAIN_TOP_ASSERT_SVH
`ifndef SYNTH
`define LRFPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrfpd same-cycle check failed");
`define LRFPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrfpd next-cycle check failed");
`else
`define LRFPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define LRFPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/lrfpd_pkg.sv]
// shared types and constants for the message ring fifo
// used by lrfpd_ctrl, lrfpd_dp and the top level
`default_nettype none

package lrfpd_pkg;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int DEF_MAX_PACKET = 64;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 8;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 7;
    localparam int DROP_W = 32;
    localparam int USED_W = 12;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DONE  = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PENDING = 3'd0,
        KIND_COMMIT  = 3'd1,
        KIND_DROP    = 3'd2,
        KIND_PACKET  = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic push;
        logic drain_start;
        logic emit;
        logic send_none;
        logic clear_busy;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic link_busy;
        logic fifo_empty;
        logic out_free;
        logic last_byte;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/lrfpd_ctrl.sv]
// control state machine of the message ring fifo: input handshake and drain sequencing
// depends on lrfpd_pkg
`default_nettype none

module lrfpd_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lrfpd_pkg::CMD_W-1:0] command,
    input  wire logic                        host_accepts,
    input  wire lrfpd_pkg::dp_stat_t         stat,
    output lrfpd_pkg::dp_cmd_t               cmd
);
    import lrfpd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready;
    logic   accept;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && stat.out_free;
        in_stall   = !in_ready;
        accept     = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PUSH:
                        begin
                            cmd.push = 1'b1;
                        end
                        CMD_DRAIN:
                        begin
                            if (stat.link_busy || stat.fifo_empty || !host_accepts)
                            begin
                                cmd.send_none = 1'b1;
                            end
                            else
                            begin
                                cmd.drain_start = 1'b1;
                                state_next      = ST_DRAIN;
                            end
                        end
                        CMD_DONE:
                        begin
                            cmd.clear_busy = 1'b1;
                            cmd.send_none  = 1'b1;
                        end
                        default:
                        begin
                            cmd.send_none = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                // one packet word per cycle while the output slot frees up
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/lrfpd_dp.sv]
// datapath of the message ring fifo: byte ring, pointers, drop counter, output register
// depends on lrfpd_pkg
`default_nettype none

module lrfpd_dp #(
    parameter int RING_DEPTH = lrfpd_pkg::DEF_RING_DEPTH,
    parameter int MAX_PACKET = lrfpd_pkg::DEF_MAX_PACKET
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [lrfpd_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic [lrfpd_pkg::DATA_W-1:0] data_byte,
    input  wire logic                         end_of_message,
    input  wire lrfpd_pkg::dp_cmd_t           cmd,
    output lrfpd_pkg::dp_stat_t               stat,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [lrfpd_pkg::KIND_W-1:0]      kind,
    output logic [lrfpd_pkg::DATA_W-1:0]      packet_byte,
    output logic                              last_of_packet,
    output logic [lrfpd_pkg::DROP_W-1:0]      dropped_count,
    output logic [lrfpd_pkg::USED_W-1:0]      bytes_used
);
    import lrfpd_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(MAX_PACKET + 1);
    localparam int CMP_W  = (PTR_W > CFG_W) ? PTR_W : CFG_W;
    localparam int UEXT_W = (PTR_W > USED_W) ? PTR_W : USED_W;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(1);
        if (s >= (PTR_W+1)'(RING_DEPTH))
        begin
            return '0;
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] tail);
        logic [PTR_W:0] s;
        s = (PTR_W+1)'(RING_DEPTH) - {1'b0, tail} + {1'b0, head};
        if (head >= tail)
        begin
            return head - tail;
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [USED_W-1:0] to_used(input logic [PTR_W-1:0] c);
        return USED_W'(UEXT_W'(c));
    endfunction

    logic [DATA_W-1:0] mem [RING_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  rd_addr;
    logic              rd_en;
    logic              mem_we;

    logic [PTR_W-1:0]  write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0]  pend_ptr_reg, pend_ptr_next;
    logic [PTR_W-1:0]  read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0]  fetch_ptr_reg, fetch_ptr_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic              busy_reg, busy_next;
    logic              discard_reg, discard_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [CFG_W-1:0]  max_len_reg;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [DROP_W-1:0] dropped_reg, dropped_next;
    logic [USED_W-1:0] used_reg, used_next;

    logic [PTR_W-1:0]  used;
    logic [PTR_W-1:0]  pend_count;
    logic              ring_full;
    logic [CFG_W-1:0]  limit;
    logic [CNT_W-1:0]  pkt_len;
    logic [PTR_W-1:0]  pend_adv;
    logic [PTR_W-1:0]  fetch_adv;
    logic              out_free;
    logic              last_byte;

    always_comb
    begin
        used       = ring_count(write_ptr_reg, read_ptr_reg);
        pend_count = ring_count(pend_ptr_reg, read_ptr_reg);
        ring_full  = pend_count >= PTR_W'(RING_DEPTH - 1);
        pend_adv   = ring_next(pend_ptr_reg);
        fetch_adv  = ring_next(fetch_ptr_reg);
        out_free   = !out_valid_reg || !out_stall;
        last_byte  = remain_reg == CNT_W'(1);

        // zero acts as one, oversize clamps to the largest packet
        if (max_len_reg == '0)
        begin
            limit = CFG_W'(1);
        end
        else if (max_len_reg > CFG_W'(MAX_PACKET))
        begin
            limit = CFG_W'(MAX_PACKET);
        end
        else
        begin
            limit = max_len_reg;
        end
        if (CMP_W'(used) > CMP_W'(limit))
        begin
            pkt_len = CNT_W'(limit);
        end
        else
        begin
            pkt_len = CNT_W'(used);
        end

        stat.link_busy  = busy_reg;
        stat.fifo_empty = used == '0;
        stat.out_free   = out_free;
        stat.last_byte  = last_byte;
    end

    always_comb
    begin
        write_ptr_next = write_ptr_reg;
        pend_ptr_next  = pend_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        fetch_ptr_next = fetch_ptr_reg;
        remain_next    = remain_reg;
        busy_next      = busy_reg;
        discard_next   = discard_reg;
        drop_next      = drop_reg;
        mem_we         = 1'b0;
        rd_en          = cmd.drain_start || cmd.emit;
        rd_addr        = cmd.drain_start ? read_ptr_reg : fetch_adv;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        dropped_next   = dropped_reg;
        used_next      = used_reg;

        if (cmd.push)
        begin
            kind_next = KIND_DROP;
            if (discard_reg)
            begin
                if (end_of_message)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (ring_full)
            begin
                // no room: rewind the open message and count it lost
                pend_ptr_next = write_ptr_reg;
                drop_next     = drop_reg + DROP_W'(1);
                discard_next  = !end_of_message;
            end
            else
            begin
                mem_we        = 1'b1;
                pend_ptr_next = pend_adv;
                if (end_of_message)
                begin
                    write_ptr_next = pend_adv;
                    kind_next      = KIND_COMMIT;
                end
                else
                begin
                    kind_next = KIND_PENDING;
                end
            end
            out_valid_next = 1'b1;
            byte_next      = '0;
            last_next      = 1'b0;
            dropped_next   = drop_next;
            used_next      = to_used(ring_count(write_ptr_next, read_ptr_reg));
        end

        if (cmd.send_none)
        begin
            if (cmd.clear_busy)
            begin
                busy_next = 1'b0;
            end
            out_valid_next = 1'b1;
            kind_next      = KIND_NONE;
            byte_next      = '0;
            last_next      = 1'b0;
            dropped_next   = drop_reg;
            used_next      = to_used(used);
        end

        if (cmd.drain_start)
        begin
            fetch_ptr_next = read_ptr_reg;
            remain_next    = pkt_len;
        end

        if (cmd.emit)
        begin
            // rd_data_reg holds the word at fetch_ptr_reg
            fetch_ptr_next = fetch_adv;
            remain_next    = remain_reg - CNT_W'(1);
            out_valid_next = 1'b1;
            kind_next      = KIND_PACKET;
            byte_next      = rd_data_reg;
            last_next      = last_byte;
            dropped_next   = drop_reg;
            used_next      = to_used(used);
            if (last_byte)
            begin
                read_ptr_next = fetch_adv;
                busy_next     = 1'b1;
                used_next     = to_used(ring_count(write_ptr_reg, fetch_adv));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pend_ptr_reg] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg <= '0;
            pend_ptr_reg  <= '0;
            read_ptr_reg  <= '0;
            fetch_ptr_reg <= '0;
            remain_reg    <= '0;
            busy_reg      <= 1'b0;
            discard_reg   <= 1'b0;
            drop_reg      <= '0;
            max_len_reg   <= CFG_W'(MAX_PACKET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            write_ptr_reg <= write_ptr_next;
            pend_ptr_reg  <= pend_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            fetch_ptr_reg <= fetch_ptr_next;
            remain_reg    <= remain_next;
            busy_reg      <= busy_next;
            discard_reg   <= discard_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        dropped_reg <= dropped_next;
        used_reg    <= used_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign packet_byte    = byte_reg;
    assign last_of_packet = last_reg;
    assign dropped_count  = dropped_reg;
    assign bytes_used     = used_reg;

endmodule

`default_nettype wire

[src/log_ring_fifo_with_packet_drain_top.sv]
// Byte ring fifo with whole-message admission and packet drain.
// Input channel (in_valid/in_stall) carries one command word: push a byte,
// drain one packet, or transmit complete. Output channel (out_valid/out_stall)
// returns one result word per push, completion or refused drain, and one word
// per packet byte for a granted drain.
// A result is loaded into the output register in the cycle after the input
// word is taken, and pushes stream at one per cycle while the output does not stall.
// A granted drain of n bytes passes each byte through the single registered
// read port of the byte ring and then the output register, one byte per cycle
// while the output does not stall; the next input word is taken once the last byte is loaded.
// A stall on the output holds the result and, once the output register is
// full, stalls the input. Reset empties the ring, clears busy, discard and the
// drop counter and sets the packet length to its maximum; no clearing pass is
// needed, the ring contents are don't-care until written.
// Depends on lrfpd_pkg, lrfpd_ctrl, lrfpd_dp and the assertion macro header.
`default_nettype none
`include "log_ring_fifo_with_packet_drain_top_assert.svh"

module log_ring_fifo_with_packet_drain_top #(
    parameter int RING_DEPTH = lrfpd_pkg::DEF_RING_DEPTH,
    parameter int MAX_PACKET = lrfpd_pkg::DEF_MAX_PACKET
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [lrfpd_pkg::CFG_W-1:0]  cfg_write_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [lrfpd_pkg::CMD_W-1:0]  command,
    input  wire logic [lrfpd_pkg::DATA_W-1:0] data_byte,
    input  wire logic                         end_of_message,
    input  wire logic                         host_accepts,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [lrfpd_pkg::KIND_W-1:0]      kind,
    output logic [lrfpd_pkg::DATA_W-1:0]      packet_byte,
    output logic                              last_of_packet,
    output logic [lrfpd_pkg::DROP_W-1:0]      dropped_count,
    output logic [lrfpd_pkg::USED_W-1:0]      bytes_used
);
    import lrfpd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_accept;
    logic     out_accept;

    lrfpd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .host_accepts (host_accepts),
        .stat         (stat),
        .cmd          (cmd)
    );

    lrfpd_dp #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .packet_byte    (packet_byte),
        .last_of_packet (last_of_packet),
        .dropped_count  (dropped_count),
        .bytes_used     (bytes_used)
    );

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    // every accepted word but a granted drain leaves a result in the output register
    `LRFPD_ASSERT_NEXT(a_result_follows, clk, rst_n, in_accept && !cmd.drain_start, out_valid)
    // mid-packet bytes come back to back once taken
    `LRFPD_ASSERT_NEXT(a_packet_continues, clk, rst_n,
        out_accept && kind == KIND_PACKET && !last_of_packet,
        out_valid && kind == KIND_PACKET)
    // no new command word while a packet is still going out
    `LRFPD_ASSERT_NOW(a_stall_in_packet, clk, rst_n,
        out_valid && kind == KIND_PACKET && !last_of_packet, in_stall)

endmodule

`default_nettype wire
